FILE: sv/smh_pkg.sv
// Shared types, codes and coil tables for the stepper move-and-home sequencer.
// No dependencies; imported by smh_if, smh_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smh_pkg;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_W     = 3;
	localparam int POS_W       = 16;
	localparam int SPS_W       = 12;
	localparam int SLOTS_W     = 7;
	localparam int PROD_W      = SPS_W + SLOTS_W;
	localparam int LIMIT_W     = PROD_W + 1;
	localparam int CROSS_W     = 24;
	localparam int COIL_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_START = 2'd1,
		ACT_SLOT  = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RUN_IDLE   = 2'd0,
		RUN_NORMAL = 2'd1,
		RUN_SEARCH = 2'd2,
		RUN_CROSS  = 2'd3
	} run_mode_t;

	localparam logic [1:0] MOVE_NORMAL = 2'd0;
	localparam logic [1:0] MOVE_SEARCH = 2'd1;
	localparam logic [1:0] MOVE_CROSS  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd2;

	localparam logic [SPS_W-1:0]   SPS_RESET   = 12'd50;
	localparam logic [SLOTS_W-1:0] SLOTS_RESET = 7'd8;

	typedef struct packed {
		action_t                 action;
		logic signed [POS_W-1:0] move_steps;
		logic [1:0]              move_mode;
		logic [SLOTS_W-1:0]      slot;
		logic                    home_sensor;
	} smh_cmd_t;

	typedef struct packed {
		run_mode_t           run_mode;
		logic                dir_neg;
		logic [POS_W-1:0]    target;
		logic [POS_W-1:0]    moved;
		logic [POS_W-1:0]    pos;
		logic [PHASE_W-1:0]  phase;
		logic                unstarted;
		logic                seen_low;
		logic [CROSS_W-1:0]  cross_cnt;
		logic [COIL_W-1:0]   coil;
		logic                homed;
		logic                home_err;
	} smh_state_t;

	typedef struct packed {
		logic               decay;
		logic [SPS_W-1:0]   sps;
		logic [SLOTS_W-1:0] slots;
	} smh_cfg_t;

	// decay 0 = slow (phase-swapped table), 1 = fast
	function automatic logic [COIL_W-1:0] coil_bits(input logic decay,
	                                                input logic [PHASE_W-1:0] ph);
		logic [COIL_W-1:0] r;
		if (decay) begin
			case (ph)
				3'd0: r = 4'hA;
				3'd1: r = 4'h6;
				3'd2: r = 4'h2;
				3'd3: r = 4'h1;
				3'd4: r = 4'h0;
				3'd5: r = 4'hC;
				3'd6: r = 4'h8;
				default: r = 4'hB;
			endcase
		end else begin
			case (ph)
				3'd0: r = 4'hA;
				3'd1: r = 4'hB;
				3'd2: r = 4'h8;
				3'd3: r = 4'hC;
				3'd4: r = 4'h0;
				3'd5: r = 4'h1;
				3'd6: r = 4'h2;
				default: r = 4'h6;
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/smh_if.sv
// Handshake channel interfaces: command in, status out, register writes.
// Depends on smh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smh_cmd_if import smh_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic signed [POS_W-1:0] move_steps;
	logic [1:0]              move_mode;
	logic [SLOTS_W-1:0]      slot;
	logic                    home_sensor;

	modport source (output valid, action, move_steps, move_mode, slot, home_sensor,
	                input ready);
	modport sink   (input valid, action, move_steps, move_mode, slot, home_sensor,
	                output ready);
endinterface

interface smh_status_if import smh_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [COIL_W-1:0]       coil_pattern;
	logic                    idle;
	logic signed [POS_W-1:0] position;
	logic                    homed;
	logic                    home_error;
	logic                    finished;

	modport source (output valid, coil_pattern, idle, position, homed, home_error,
	                finished, input ready);
	modport sink   (input valid, coil_pattern, idle, position, homed, home_error,
	                finished, output ready);
endinterface

interface smh_cfg_if import smh_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/smh_step.sv
// Next-state logic for one command beat: tick, start, slot move or stop.
// Depends on smh_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module smh_step import smh_pkg::*; (
	input  smh_cmd_t   cmd,
	input  smh_state_t cur,
	input  smh_cfg_t   cfg,
	output smh_state_t nxt,
	output logic       finished
);

	localparam logic [PHASE_W-1:0] LAST = PHASE_W'(PHASE_COUNT - 1);

	logic [POS_W-1:0]   delta;
	logic [PHASE_W-1:0] phase_n;
	logic [PROD_W-1:0]  slot_dest;
	logic [POS_W-1:0]   slot_steps;
	logic [LIMIT_W-1:0] limit;
	logic [CROSS_W-1:0] cross_inc;
	logic               cross_home;
	logic               cross_fail;

	function automatic smh_state_t start_move(input smh_state_t s,
	                                         input logic [POS_W-1:0] steps,
	                                         input logic [1:0] mode);
		smh_state_t r;
		r = s;
		if (steps == '0 || mode > MOVE_CROSS) begin
			r.run_mode = RUN_IDLE;
		end else begin
			r.dir_neg = steps[POS_W-1];
			r.target  = steps;
			r.moved   = '0;
			case (mode)
				MOVE_NORMAL: r.run_mode = RUN_NORMAL;
				MOVE_SEARCH: r.run_mode = RUN_SEARCH;
				default:     r.run_mode = RUN_CROSS;
			endcase
		end
		return r;
	endfunction

	always_comb begin
		if (cur.unstarted) begin
			phase_n = cur.dir_neg ? LAST : '0;
		end else if (cur.dir_neg) begin
			phase_n = (cur.phase == '0 || cur.phase > LAST) ? LAST : cur.phase - 1'b1;
		end else begin
			phase_n = (cur.phase >= LAST) ? '0 : cur.phase + 1'b1;
		end
	end

	assign delta      = cur.dir_neg ? '1 : POS_W'(1);
	assign slot_dest  = PROD_W'(cmd.slot) * PROD_W'(cfg.sps);
	assign slot_steps = slot_dest[POS_W-1:0] - cur.pos;
	assign limit      = {PROD_W'(cfg.sps) * PROD_W'(cfg.slots), 1'b0};
	assign cross_inc  = cur.cross_cnt + 1'b1;
	assign cross_home = cur.seen_low && cmd.home_sensor;
	assign cross_fail = cross_inc > CROSS_W'(limit);

	always_comb begin
		nxt = cur;
		case (cmd.action)
			ACT_TICK: begin
				if (cur.run_mode != RUN_IDLE) begin
					nxt.phase     = phase_n;
					nxt.unstarted = 1'b0;
					nxt.coil      = coil_bits(cfg.decay, phase_n);
					nxt.moved     = cur.moved + delta;
				end
				case (cur.run_mode)
					RUN_NORMAL: begin
						nxt.pos = cur.pos + delta;
						if (nxt.moved == cur.target) begin
							nxt.target   = '0;
							nxt.run_mode = RUN_IDLE;
						end
					end
					RUN_SEARCH: begin
						nxt.pos = cur.pos + delta;
						if (!cmd.home_sensor) begin
							nxt.homed    = 1'b1;
							nxt.home_err = 1'b0;
							nxt.target   = '0;
							nxt.run_mode = RUN_IDLE;
						end else if (nxt.moved == cur.target) begin
							nxt.homed    = 1'b0;
							nxt.home_err = 1'b1;
							nxt.target   = '0;
							nxt.run_mode = RUN_IDLE;
						end
					end
					RUN_CROSS: begin
						nxt.cross_cnt = cross_inc;
						if (!cur.seen_low && !cmd.home_sensor) begin
							nxt.seen_low = 1'b1;
						end
						if (cross_home) begin
							nxt.pos = '0;
						end
						if (cross_home || cross_fail) begin
							nxt.cross_cnt = '0;
							nxt.seen_low  = 1'b0;
							nxt.homed     = !cross_fail;
							nxt.home_err  = cross_fail;
							nxt.target    = '0;
							nxt.run_mode  = RUN_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			ACT_START: begin
				nxt = start_move(cur, cmd.move_steps, cmd.move_mode);
			end
			ACT_SLOT: begin
				nxt = start_move(cur, slot_steps, MOVE_NORMAL);
			end
			default: begin
				nxt.target   = '0;
				nxt.run_mode = RUN_IDLE;
			end
		endcase
	end

	assign finished = (cur.run_mode != RUN_IDLE) && (nxt.run_mode == RUN_IDLE);

endmodule

`default_nettype wire

FILE: sv/stepper_move_and_home_sequencer_top.sv
// Top level of the stepper move-and-home sequencer.
// Depends on smh_pkg, smh_if and smh_step.
//
// Usage:
//  cmd    - one beat per action: tick, start move, move to slot, stop.
//  status - one beat per command: coil pattern, idle, position, homing
//           flags and a finished strobe, all as they stand after the action.
//  cfg    - register writes (decay mode, steps per slot, slot count); always
//           ready, to be written only while no command is in flight.
// A command beat is registered in the input register, worked through the step
// logic and lands in the status register with the updated motor state. One
// command per cycle is sustained while the status receiver keeps up; the motor
// state loop closes through the combinational step logic alone.
// The cmd and status sides are parted by the status register: a stalled
// receiver holds status, one further command waits in the input register, and
// cmd.ready drops only when both are full.
// Reset clears the motor state, homing flags and both registers' valid flags;
// the configuration returns to slow decay, 50 steps per slot and 8 slots.
`timescale 1ns / 1ps
`default_nettype none

module stepper_move_and_home_sequencer_top import smh_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	smh_cmd_if.sink          cmd,
	smh_status_if.source     status,
	smh_cfg_if.sink          cfg
);

	localparam smh_state_t STATE_RESET = '{
		run_mode:  RUN_IDLE,
		dir_neg:   1'b0,
		target:    '0,
		moved:     '0,
		pos:       '0,
		phase:     '0,
		unstarted: 1'b1,
		seen_low:  1'b0,
		cross_cnt: '0,
		coil:      '0,
		homed:     1'b0,
		home_err:  1'b0
	};

	logic       valid_s1;
	smh_cmd_t   cmd_s1;
	smh_state_t state_q;
	smh_state_t state_n;
	smh_cfg_t   cfg_q;
	logic       finished_n;
	logic       advance;
	logic       out_valid_q;

	assign advance   = valid_s1 && (!out_valid_q || status.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay <= 1'b0;
			cfg_q.sps   <= SPS_RESET;
			cfg_q.slots <= SLOTS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DECAY: cfg_q.decay <= cfg.data[0];
				CFG_SPS:   cfg_q.sps   <= cfg.data[SPS_W-1:0];
				CFG_SLOTS: cfg_q.slots <= cfg.data[SLOTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.action      <= action_t'(cmd.action);
			cmd_s1.move_steps  <= cmd.move_steps;
			cmd_s1.move_mode   <= cmd.move_mode;
			cmd_s1.slot        <= cmd.slot;
			cmd_s1.home_sensor <= cmd.home_sensor;
		end
	end

	smh_step u_step (
		.cmd      (cmd_s1),
		.cur      (state_q),
		.cfg      (cfg_q),
		.nxt      (state_n),
		.finished (finished_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status.coil_pattern <= state_n.coil;
			status.idle         <= (state_n.run_mode == RUN_IDLE);
			status.position     <= state_n.pos;
			status.homed        <= state_n.homed;
			status.home_error   <= state_n.home_err;
			status.finished     <= finished_n;
		end
	end

	assign status.valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/smh_checker.sv
// Port-level checks for the sequencer top and the bind that attaches them.
// Depends on smh_if through the top level's interface ports.
`timescale 1ns / 1ps
`default_nettype none

module smh_checker (
	input wire clk,
	input wire arst_n,
	input wire cmd_valid,
	input wire cmd_ready,
	input wire st_valid,
	input wire st_ready,
	input wire st_idle,
	input wire st_homed,
	input wire st_home_error,
	input wire st_finished
);

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && !st_ready |=> st_valid)
		else $error("status beat dropped while stalled");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid && st_finished |-> st_idle)
		else $error("finished reported on a busy motor");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		st_valid |-> !(st_homed && st_home_error))
		else $error("homed and home error both set");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !st_valid |-> ##2 st_valid)
		else $error("status beat missing two cycles after command");

endmodule

bind stepper_move_and_home_sequencer_top smh_checker u_smh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.st_valid      (status.valid),
	.st_ready      (status.ready),
	.st_idle       (status.idle),
	.st_homed      (status.homed),
	.st_home_error (status.home_error),
	.st_finished   (status.finished)
);

`default_nettype wire
